[sv/tcbl_pkg.sv]
// ----------------------------------------------------------------------------
// tcbl_pkg: shared types and constants for the two-choice bin loader
// Beat payloads, sequencer states and the control word for the cell ring.
// ----------------------------------------------------------------------------
package tcbl_pkg;

  localparam int unsigned BIN_W      = 6;   // bin index field width
  localparam int unsigned LOAD_OUT_W = 16;  // load fields on the result beat
  localparam int unsigned QD_W       = 2;   // query_depth register width

  localparam logic [QD_W-1:0] QD_RESET = 2'd1;  // median question only
  localparam logic [QD_W-1:0] QD_TWO   = 2'd2;  // median plus upper quartile

  typedef struct packed {
    logic [BIN_W-1:0] first_bin;
    logic [BIN_W-1:0] second_bin;
    logic             coin;
  } ball_t;

  typedef struct packed {
    logic [BIN_W-1:0]      chosen_bin;
    logic [LOAD_OUT_W-1:0] chosen_load;
    logic [LOAD_OUT_W-1:0] max_load;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FIND,
    ST_COUNT,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic shift;  // every cell takes its neighbour's contents
    logic bump;   // cell holding the picked bin increments its load
  } ring_ctrl_t;

endpackage

[sv/tcbl_stream_if.sv]
// ----------------------------------------------------------------------------
// tcbl_stream_if: valid/ready channel
// One beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tcbl_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[sv/two_choice_bin_loader.sv]
// ----------------------------------------------------------------------------
// two_choice_bin_loader: power-of-two-choices ball placement
// Ring of load cells plus a sequencer that ranks both candidates against
// the median (and optionally the upper quartile) and places one ball.
// ----------------------------------------------------------------------------
//
//  port       dir  beat contents                         handshake
//  ---------  ---  ------------------------------------  -----------------
//  ball_i     in   first_bin, second_bin, coin           valid / ready
//  result_o   out  chosen_bin, chosen_load, max_load     valid / ready
//  cfg_*      in   query_depth (2 bits)                  write enable only
//
//  Each ball goes through index reduction when NUM_BINS < 64, then two full
//  turns of the cell ring: the first to pick up both candidate loads, the
//  second to count smaller loads.
//  Reset clears every load, the peak and the result slot; query_depth = 1.
//  A held result beat does not block the next ball until that ball's own
//  result is ready to be written.
//
module two_choice_bin_loader #(
  parameter int unsigned NUM_BINS   = 64,
  parameter int unsigned LOAD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tcbl_pkg::QD_W-1:0] cfg_wdata_i,
  tcbl_stream_if.sink               ball_i,
  tcbl_stream_if.source             result_o
);

  localparam int unsigned TAG_W = $clog2(NUM_BINS);

  tcbl_pkg::ring_ctrl_t  ring;
  logic [TAG_W-1:0]      pick_tag;

  // ring links: cell k takes from cell k-1, cell 0 from the last one.
  // The last cell is the head the sequencer looks at.
  logic [LOAD_WIDTH-1:0] load_w [NUM_BINS];
  logic [TAG_W-1:0]      tag_w  [NUM_BINS];

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    localparam int unsigned PREV = (k == 0) ? NUM_BINS - 1 : k - 1;
    tcbl_cell #(
      .LOAD_WIDTH (LOAD_WIDTH),
      .TAG_W      (TAG_W),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ring_i     (ring),
      .pick_tag_i (pick_tag),
      .load_i     (load_w[PREV]),
      .tag_i      (tag_w[PREV]),
      .load_o     (load_w[k]),
      .tag_o      (tag_w[k])
    );
  end

  // sequencer: index reduction, find turn, count turn, decide, update
  tcbl_ctrl #(
    .NUM_BINS   (NUM_BINS),
    .LOAD_WIDTH (LOAD_WIDTH),
    .TAG_W      (TAG_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ball_i      (ball_i),
    .result_o    (result_o),
    .head_load_i (load_w[NUM_BINS-1]),
    .head_tag_i  (tag_w[NUM_BINS-1]),
    .ring_o      (ring),
    .pick_tag_o  (pick_tag)
  );

endmodule

[sv/tcbl_cell.sv]
// ----------------------------------------------------------------------------
// tcbl_cell: one link of the load ring
// Holds one bin's load and tag; passes both on when the ring shifts.
// ----------------------------------------------------------------------------
module tcbl_cell #(
  parameter int unsigned LOAD_WIDTH = 16,
  parameter int unsigned TAG_W      = 6,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcbl_pkg::ring_ctrl_t   ring_i,
  input  logic [TAG_W-1:0]       pick_tag_i,
  input  logic [LOAD_WIDTH-1:0]  load_i,
  input  logic [TAG_W-1:0]       tag_i,
  output logic [LOAD_WIDTH-1:0]  load_o,
  output logic [TAG_W-1:0]       tag_o
);

  logic [LOAD_WIDTH-1:0] load_q;
  logic [TAG_W-1:0]      tag_q;
  logic                  hit;

  assign hit = ring_i.bump && (tag_q == pick_tag_i) && (load_q != {LOAD_WIDTH{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      tag_q  <= TAG_W'(CELL_IDX);
    end else if (ring_i.shift) begin
      load_q <= load_i;
      tag_q  <= tag_i;
    end else if (hit) begin
      load_q <= load_q + 1'b1;  // saturates: no bump at all ones
    end
  end

  assign load_o = load_q;
  assign tag_o  = tag_q;

endmodule

[sv/tcbl_ctrl.sv]
// ----------------------------------------------------------------------------
// tcbl_ctrl: ball sequencer
// Reduces indices, finds both candidate loads at the ring head, counts
// smaller loads, picks a bin and drives the result register.
// ----------------------------------------------------------------------------
module tcbl_ctrl #(
  parameter int unsigned NUM_BINS   = 64,
  parameter int unsigned LOAD_WIDTH = 16,
  parameter int unsigned TAG_W      = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcbl_pkg::QD_W-1:0]     cfg_wdata_i,
  tcbl_stream_if.sink                   ball_i,
  tcbl_stream_if.source                 result_o,
  input  logic [LOAD_WIDTH-1:0]         head_load_i,
  input  logic [TAG_W-1:0]              head_tag_i,
  output tcbl_pkg::ring_ctrl_t          ring_o,
  output logic [TAG_W-1:0]              pick_tag_o
);

  localparam int unsigned IDX_W = (TAG_W > tcbl_pkg::BIN_W) ? TAG_W : tcbl_pkg::BIN_W;
  localparam int unsigned CNT_W = $clog2(NUM_BINS + 1);
  localparam logic [IDX_W:0]      NB_EXT   = (IDX_W + 1)'(NUM_BINS);
  localparam logic [TAG_W-1:0]    STEP_END = TAG_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0]    RANK_MED = CNT_W'(NUM_BINS / 2);
  localparam logic [CNT_W-1:0]    RANK_UP  = CNT_W'((NUM_BINS * 3) / 4);

  tcbl_pkg::state_e state_q, state_d;

  logic [TAG_W-1:0]            step_q;
  logic [tcbl_pkg::QD_W-1:0]   qd_q;
  logic [LOAD_WIDTH-1:0]       peak_q, peak_d;
  logic                        res_valid_q;
  tcbl_pkg::result_t           res_q;

  logic [IDX_W-1:0]            a_q, b_q, pick_q;
  logic                        coin_q;
  logic [LOAD_WIDTH-1:0]       la_q, lb_q, new_load_q;
  logic [CNT_W-1:0]            cnt_a_q, cnt_b_q;

  logic a_ok, b_ok, last_step, slot_free, accept, res_load;
  logic fa, fb, ga, gb, pick_b;
  logic [IDX_W-1:0]            pick_d;
  logic [LOAD_WIDTH-1:0]       l_pick, sat_load;
  logic [LOAD_WIDTH+tcbl_pkg::LOAD_OUT_W-1:0] new_ext, peak_ext;

  assign a_ok      = {1'b0, a_q} < NB_EXT;
  assign b_ok      = {1'b0, b_q} < NB_EXT;
  assign last_step = step_q == STEP_END;
  assign slot_free = !res_valid_q || result_o.ready;
  assign accept    = ball_i.valid && ball_i.ready;

  // decision on the finished counts
  assign fa = cnt_a_q > RANK_MED;
  assign fb = cnt_b_q > RANK_MED;
  assign ga = cnt_a_q > RANK_UP;
  assign gb = cnt_b_q > RANK_UP;

  always_comb begin
    if (fa != fb) begin
      pick_b = fa;
    end else if ((qd_q == tcbl_pkg::QD_TWO) && (ga != gb)) begin
      pick_b = ga;
    end else begin
      pick_b = coin_q;
    end
  end

  assign pick_d   = pick_b ? b_q : a_q;
  assign l_pick   = pick_b ? lb_q : la_q;
  assign sat_load = (l_pick == {LOAD_WIDTH{1'b1}}) ? l_pick : l_pick + 1'b1;
  assign peak_d   = (new_load_q > peak_q) ? new_load_q : peak_q;
  assign new_ext  = {{tcbl_pkg::LOAD_OUT_W{1'b0}}, new_load_q};
  assign peak_ext = {{tcbl_pkg::LOAD_OUT_W{1'b0}}, peak_d};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcbl_pkg::ST_IDLE:   if (ball_i.valid) state_d = tcbl_pkg::ST_REDUCE;
      tcbl_pkg::ST_REDUCE: if (a_ok && b_ok) state_d = tcbl_pkg::ST_FIND;
      tcbl_pkg::ST_FIND:   if (last_step) state_d = tcbl_pkg::ST_COUNT;
      tcbl_pkg::ST_COUNT:  if (last_step) state_d = tcbl_pkg::ST_DECIDE;
      tcbl_pkg::ST_DECIDE: state_d = tcbl_pkg::ST_UPDATE;
      tcbl_pkg::ST_UPDATE: if (slot_free) state_d = tcbl_pkg::ST_IDLE;
      default:             state_d = tcbl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ball_i.ready = 1'b0;
    ring_o.shift = 1'b0;
    ring_o.bump  = 1'b0;
    res_load     = 1'b0;
    case (state_q)
      tcbl_pkg::ST_IDLE:   ball_i.ready = 1'b1;
      tcbl_pkg::ST_FIND,
      tcbl_pkg::ST_COUNT:  ring_o.shift = 1'b1;
      tcbl_pkg::ST_UPDATE: begin
        ring_o.bump = slot_free;
        res_load    = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcbl_pkg::ST_IDLE;
      step_q      <= '0;
      qd_q        <= tcbl_pkg::QD_RESET;
      peak_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        qd_q <= cfg_wdata_i;
      end
      if (ring_o.shift) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
      end
      if (res_load) begin
        peak_q      <= peak_d;
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= IDX_W'(ball_i.payload.first_bin);
      b_q     <= IDX_W'(ball_i.payload.second_bin);
      coin_q  <= ball_i.payload.coin;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end
    if (state_q == tcbl_pkg::ST_REDUCE) begin
      if (!a_ok) a_q <= a_q - NB_EXT[IDX_W-1:0];
      if (!b_ok) b_q <= b_q - NB_EXT[IDX_W-1:0];
    end
    if (state_q == tcbl_pkg::ST_FIND) begin
      if (head_tag_i == a_q[TAG_W-1:0]) la_q <= head_load_i;
      if (head_tag_i == b_q[TAG_W-1:0]) lb_q <= head_load_i;
    end
    if (state_q == tcbl_pkg::ST_COUNT) begin
      if (head_load_i < la_q) cnt_a_q <= cnt_a_q + 1'b1;
      if (head_load_i < lb_q) cnt_b_q <= cnt_b_q + 1'b1;
    end
    if (state_q == tcbl_pkg::ST_DECIDE) begin
      pick_q     <= pick_d;
      new_load_q <= sat_load;
    end
    if (res_load) begin
      res_q.chosen_bin  <= pick_q[tcbl_pkg::BIN_W-1:0];
      res_q.chosen_load <= new_ext[tcbl_pkg::LOAD_OUT_W-1:0];
      res_q.max_load    <= peak_ext[tcbl_pkg::LOAD_OUT_W-1:0];
    end
  end

  assign pick_tag_o       = pick_q[TAG_W-1:0];
  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

endmodule
